### rtl/core/gntt_pkg.sv
`timescale 1ns / 1ps

package gntt_pkg;

    localparam int COORD_W    = 16;
    localparam int MOM_W      = 24;
    localparam int POS_W      = 12;
    localparam int FWHM_W     = 20;
    localparam int ECC_W      = 16;
    localparam int CNT_W      = 8;
    localparam int GATE_W     = 16;
    localparam int DIM_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int K_W        = 18;

    // 2.355 in Q16
    localparam logic [K_W-1:0]    FWHM_K   = K_W'(154337);
    localparam logic [FWHM_W-1:0] FWHM_MAX = '1;
    localparam logic [ECC_W-1:0]  ECC_MAX  = '1;

    typedef enum logic [1:0] {
        CMD_CAND  = 2'd0,
        CMD_EMPTY = 2'd1,
        CMD_RESET = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SUCC_START = 3'd0,
        REG_FAIL_DROP  = 3'd1,
        REG_GATE       = 3'd2,
        REG_FRAME_W    = 3'd3,
        REG_FRAME_H    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        t_cmd                      command;
        logic                      star_mode;
        logic [COORD_W-1:0]        cand_x;
        logic [COORD_W-1:0]        cand_y;
        logic [MOM_W-1:0]          var_x;
        logic [MOM_W-1:0]          var_y;
        logic signed [MOM_W-1:0]   cov_xy;
        logic                      last_candidate;
    } t_in;

    typedef struct packed {
        logic                 found;
        logic [POS_W-1:0]     pos_x;
        logic [POS_W-1:0]     pos_y;
        logic [FWHM_W-1:0]    fwhm;
        logic [ECC_W-1:0]     eccentricity;
        logic                 tracking;
    } t_out;

    typedef struct packed {
        logic [CNT_W-1:0]  succ_start;
        logic [CNT_W-1:0]  fail_drop;
        logic [GATE_W-1:0] gate_radius;
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
    } t_cfg;

    // frame-end job handed from the front to the shape unit
    typedef struct packed {
        logic                found;
        logic                tracking;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [MOM_W-1:0]    var_a;
        logic [MOM_W-1:0]    var_b;
        logic [MOM_W-1:0]    cov;
    } t_job;

endpackage

### rtl/core/gntt_front.sv
`timescale 1ns / 1ps

module gntt_front import gntt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_item,
    output logic o_job_valid,
    input  logic i_job_ready,
    output t_job o_job
);

    localparam int DIST_W = 2 * COORD_W + 1;

    typedef enum logic [1:0] {F_IDLE, F_DIST, F_PICK, F_PUSH} t_fstate;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    t_fstate              r_state;
    t_in                  r_item;
    logic                 r_track;
    logic [CNT_W-1:0]     r_succ;
    logic [CNT_W-1:0]     r_fail;
    logic [COORD_W-1:0]   r_pred_x, r_pred_y;
    logic                 r_best_valid;
    logic [DIST_W-1:0]    r_best_dist;
    logic [DIST_W-1:0]    r_dist;
    logic [COORD_W-1:0]   r_best_x, r_best_y;
    logic [MOM_W-1:0]     r_best_a, r_best_b, r_best_c;
    t_job                 r_job;

    logic [COORD_W-1:0]   c_x, c_y, dx, dy;
    logic [2*COORD_W-1:0] sq_x, sq_y;
    logic                 take;
    logic [COORD_W-1:0]   sel_x, sel_y, gdx, gdy;
    logic [MOM_W-1:0]     sel_a, sel_b, sel_c;
    logic [CNT_W-1:0]     succ_inc, fail_inc;
    logic                 gate_fail;
    t_job                 pick_job, empty_job;

    assign o_ready     = (r_state == F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job       = r_job;

    // squared distance to the search center
    always_comb begin
        c_x  = r_track ? r_pred_x : COORD_W'({i_cfg.frame_width, 3'b000});
        c_y  = r_track ? r_pred_y : COORD_W'({i_cfg.frame_height, 3'b000});
        dx   = (r_item.cand_x >= c_x) ? r_item.cand_x - c_x : c_x - r_item.cand_x;
        dy   = (r_item.cand_y >= c_y) ? r_item.cand_y - c_y : c_y - r_item.cand_y;
        sq_x = dx * dx;
        sq_y = dy * dy;
    end

    // keep or replace the best candidate, then judge the frame
    always_comb begin
        if (!r_best_valid) begin
            take = 1'b1;
        end else if (!r_track && r_item.star_mode) begin
            take = 1'b0;
        end else begin
            take = r_dist < r_best_dist;
        end
        sel_x = take ? r_item.cand_x : r_best_x;
        sel_y = take ? r_item.cand_y : r_best_y;
        sel_a = take ? r_item.var_x : r_best_a;
        sel_b = take ? r_item.var_y : r_best_b;
        sel_c = take ? r_item.cov_xy : r_best_c;
        gdx   = (sel_x >= r_pred_x) ? sel_x - r_pred_x : r_pred_x - sel_x;
        gdy   = (sel_y >= r_pred_y) ? sel_y - r_pred_y : r_pred_y - sel_y;
        gate_fail = (gdx > i_cfg.gate_radius) || (gdy > i_cfg.gate_radius);
        succ_inc  = sat_inc(r_succ);
        fail_inc  = sat_inc(r_fail);
    end

    // frame results for a closing candidate and for an empty frame
    always_comb begin
        empty_job          = '0;
        empty_job.tracking = r_track && !(fail_inc >= i_cfg.fail_drop);
        pick_job           = '0;
        pick_job.var_a     = sel_a;
        pick_job.var_b     = sel_b;
        pick_job.cov       = sel_c;
        priority if (!r_track) begin
            pick_job.found    = 1'b1;
            pick_job.pos_x    = sel_x[COORD_W-1 -: POS_W];
            pick_job.pos_y    = sel_y[COORD_W-1 -: POS_W];
            pick_job.tracking = succ_inc >= i_cfg.succ_start;
        end else if (gate_fail) begin
            pick_job.tracking = !(fail_inc >= i_cfg.fail_drop);
        end else begin
            pick_job.found    = 1'b1;
            pick_job.pos_x    = sel_x[COORD_W-1 -: POS_W];
            pick_job.pos_y    = sel_y[COORD_W-1 -: POS_W];
            pick_job.tracking = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_track      <= 1'b0;
            r_succ       <= '0;
            r_fail       <= '0;
            r_pred_x     <= '0;
            r_pred_y     <= '0;
            r_best_valid <= 1'b0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_item <= i_item;
                        unique case (i_item.command)
                            CMD_RESET: begin
                                r_track      <= 1'b0;
                                r_succ       <= '0;
                                r_fail       <= '0;
                                r_pred_x     <= '0;
                                r_pred_y     <= '0;
                                r_best_valid <= 1'b0;
                            end
                            CMD_EMPTY: begin
                                r_best_valid <= 1'b0;
                                r_succ       <= '0;
                                r_fail       <= fail_inc;
                                if (fail_inc >= i_cfg.fail_drop) begin
                                    r_track <= 1'b0;
                                end
                                r_job   <= empty_job;
                                r_state <= F_PUSH;
                            end
                            CMD_CAND: begin
                                r_state <= F_DIST;
                            end
                            CMD_NONE: begin
                                r_state <= F_IDLE;
                            end
                        endcase
                    end
                end
                F_DIST: begin
                    r_dist  <= DIST_W'(sq_x) + DIST_W'(sq_y);
                    r_state <= F_PICK;
                end
                F_PICK: begin
                    if (r_item.last_candidate) begin
                        r_best_valid <= 1'b0;
                        r_job        <= pick_job;
                        priority if (!r_track) begin
                            r_succ <= succ_inc;
                            r_fail <= '0;
                            if (succ_inc >= i_cfg.succ_start) begin
                                r_track  <= 1'b1;
                                r_pred_x <= sel_x;
                                r_pred_y <= sel_y;
                            end
                        end else if (gate_fail) begin
                            r_fail <= fail_inc;
                            if (fail_inc >= i_cfg.fail_drop) begin
                                r_track <= 1'b0;
                            end
                        end else begin
                            r_succ   <= succ_inc;
                            r_fail   <= '0;
                            r_pred_x <= sel_x;
                            r_pred_y <= sel_y;
                        end
                        r_state <= F_PUSH;
                    end else begin
                        if (take) begin
                            r_best_valid <= 1'b1;
                            r_best_dist  <= r_dist;
                            r_best_x     <= sel_x;
                            r_best_y     <= sel_y;
                            r_best_a     <= sel_a;
                            r_best_b     <= sel_b;
                            r_best_c     <= sel_c;
                        end
                        r_state <= F_IDLE;
                    end
                end
                F_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/gntt_queue.sv
`timescale 1ns / 1ps

module gntt_queue import gntt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_ready,
    input  t_job i_data,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_data
);

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    // hold the queued jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### rtl/core/gntt_shape.sv
`timescale 1ns / 1ps

module gntt_shape import gntt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    output logic o_job_pop,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_result
);

    localparam int L_W    = MOM_W + 2;
    localparam int Q_W    = 33;
    localparam int DIV_N  = 33;
    localparam int SQ_A   = 2 * MOM_W;
    localparam int SQ_B   = L_W + 23 + ((L_W + 23) % 2);
    localparam int SQ_AB  = (SQ_A > SQ_B) ? SQ_A : SQ_B;
    localparam int SQ_W   = (SQ_AB > Q_W + 1) ? SQ_AB : Q_W + 1;
    localparam int RT_W   = SQ_W / 2;
    localparam int RM_W   = RT_W + 3;
    localparam int FP_W   = RT_W + K_W;
    localparam int CMAX   = (RT_W > DIV_N) ? RT_W : DIV_N;
    localparam int CN_W   = $clog2(CMAX + 1);

    typedef enum logic [3:0] {
        B_IDLE, B_MDD, B_MCC, B_S1, B_L, B_S2, B_FM, B_DIV, B_S3, B_OUT
    } t_bstate;

    t_bstate              r_state;
    logic [CN_W-1:0]      r_cnt;
    logic                 r_found, r_track;
    logic [POS_W-1:0]     r_px, r_py;
    logic [MOM_W-1:0]     r_a, r_b, r_c;
    logic [2*MOM_W-1:0]   r_dd;
    logic [L_W-1:0]       r_l1, r_l2;
    logic [FP_W-1:0]      r_fprod;
    logic [L_W:0]         r_rem;
    logic [Q_W-1:0]       r_q;
    logic [ECC_W-1:0]     r_ecc;
    logic [SQ_W-1:0]      r_sq_val;
    logic [RM_W-1:0]      r_sq_rem;
    logic [RT_W-1:0]      r_sq_root;
    logic                 r_out_valid;
    t_out                 r_out;

    logic [RM_W-1:0]      sq_shift, sq_trial, n_sq_rem;
    logic                 sq_ge;
    logic [RT_W-1:0]      n_sq_root;
    logic                 sq_last;
    logic [MOM_W-1:0]     d_ab, c_abs;
    logic [L_W-1:0]       ab, s2, l1, l2;
    logic [L_W:0]         dv_t;
    logic                 dv_ge;
    logic [Q_W-1:0]       n_q;
    logic [FP_W:0]        f_round;
    logic [FP_W-24:0]     f_sh;
    logic [FWHM_W-1:0]    fwhm;
    logic [ECC_W-1:0]     ecc_sat;
    logic                 out_load;

    assign o_job_pop = (r_state == B_IDLE) && i_job_valid;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;
    assign out_load  = (r_state == B_OUT) && (!r_out_valid || i_ready);

    // one step of the shared square-root unit, two radicand bits a cycle
    always_comb begin
        sq_shift  = {r_sq_rem[RM_W-3:0], r_sq_val[SQ_W-1 -: 2]};
        sq_trial  = {1'b0, r_sq_root, 2'b01};
        sq_ge     = sq_shift >= sq_trial;
        n_sq_rem  = sq_ge ? sq_shift - sq_trial : sq_shift;
        n_sq_root = {r_sq_root[RT_W-2:0], sq_ge};
        sq_last   = (r_cnt == CN_W'(RT_W - 1));
    end

    // moments and eigenvalue sums
    always_comb begin
        d_ab  = (r_a >= r_b) ? r_a - r_b : r_b - r_a;
        c_abs = i_job.cov[MOM_W-1] ? ~i_job.cov + 1'b1 : i_job.cov;
        ab    = L_W'(r_a) + L_W'(r_b);
        s2    = L_W'({r_sq_root[MOM_W-1:0], 1'b0});
        l1    = ab + s2;
        l2    = (ab > s2) ? ab - s2 : '0;
    end

    // restoring divide step, first step compares without a shift
    always_comb begin
        dv_t  = (r_cnt == '0) ? r_rem : {r_rem[L_W-1:0], 1'b0};
        dv_ge = dv_t >= {1'b0, r_l1};
        n_q   = ((r_cnt == '0) ? r_q : {r_q[Q_W-2:0], 1'b0}) | Q_W'(dv_ge);
    end

    // round and saturate results
    always_comb begin
        f_round = {1'b0, r_fprod} + (FP_W + 1)'(1 << 23);
        f_sh    = f_round[FP_W:24];
        fwhm    = (f_sh > (FP_W - 23)'(FWHM_MAX)) ? FWHM_MAX : f_sh[FWHM_W-1:0];
        ecc_sat = (r_sq_root > RT_W'(ECC_MAX)) ? ECC_MAX : r_sq_root[ECC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a finished result or drop the one taken downstream
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_found <= i_job.found;
                        r_track <= i_job.tracking;
                        r_px    <= i_job.pos_x;
                        r_py    <= i_job.pos_y;
                        r_a     <= i_job.var_a;
                        r_b     <= i_job.var_b;
                        r_c     <= c_abs;
                        r_ecc   <= '0;
                        r_state <= i_job.found ? B_MDD : B_OUT;
                    end
                end
                B_MDD: begin
                    r_dd    <= d_ab * d_ab;
                    r_state <= B_MCC;
                end
                B_MCC: begin
                    r_sq_val  <= SQ_W'((r_dd >> 2) + (r_c * r_c));
                    r_sq_rem  <= '0;
                    r_sq_root <= '0;
                    r_cnt     <= '0;
                    r_state   <= B_S1;
                end
                B_S1, B_S2, B_S3: begin
                    r_sq_val  <= {r_sq_val[SQ_W-3:0], 2'b00};
                    r_sq_rem  <= n_sq_rem;
                    r_sq_root <= n_sq_root;
                    if (sq_last) begin
                        r_cnt <= '0;
                        priority case (r_state)
                            B_S1:    r_state <= B_L;
                            B_S2:    r_state <= B_FM;
                            default: r_state <= B_OUT;
                        endcase
                        if (r_state == B_S3) begin
                            r_ecc <= (n_sq_root > RT_W'(ECC_MAX)) ? ECC_MAX
                                                                  : n_sq_root[ECC_W-1:0];
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                B_L: begin
                    r_l1      <= l1;
                    r_l2      <= l2;
                    r_sq_val  <= SQ_W'({l1, 23'b0});
                    r_sq_rem  <= '0;
                    r_sq_root <= '0;
                    r_cnt     <= '0;
                    r_state   <= B_S2;
                end
                B_FM: begin
                    r_fprod <= r_sq_root * FWHM_K;
                    r_rem   <= {1'b0, r_l1 - r_l2};
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= (r_l1 == '0) ? B_OUT : B_DIV;
                end
                B_DIV: begin
                    r_rem <= dv_ge ? dv_t - {1'b0, r_l1} : dv_t;
                    r_q   <= n_q;
                    if (r_cnt == CN_W'(DIV_N - 1)) begin
                        r_sq_val  <= SQ_W'(n_q);
                        r_sq_rem  <= '0;
                        r_sq_root <= '0;
                        r_cnt     <= '0;
                        r_state   <= B_S3;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                B_OUT: begin
                    if (out_load) begin
                        r_out.found        <= r_found;
                        r_out.pos_x        <= r_found ? r_px : '0;
                        r_out.pos_y        <= r_found ? r_py : '0;
                        r_out.fwhm         <= r_found ? fwhm : '0;
                        r_out.eccentricity <= r_found ? r_ecc : '0;
                        r_out.tracking     <= r_track;
                        r_state            <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/gated_nearest_target_tracker.sv
`timescale 1ns / 1ps

// Gated nearest-target tracker. Candidates of a frame arrive one item each,
// brightest first, the final one flagged last; an empty frame is one item.
// The front takes one candidate at a time through accept, squared distance
// and pick, and at frame end hands the frame's result to a two-entry queue,
// waiting while the queue is full. The shape unit behind it computes FWHM
// and eccentricity per frame with one shared square-root unit (two bits a
// cycle, run three times) and a one-bit-a-cycle 33-step divider; a frame
// with no accepted candidate skips both and goes straight to the output.
// That unit sets the sustained frame rate; the queue lets the front keep
// taking candidates while up to two frame results wait. The output register
// holds one finished result. Configuration writes are taken at any time and
// should be made only while the block is idle.
module gated_nearest_target_tracker import gntt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_item
);

    t_cfg r_cfg;
    logic job_valid, job_ready, q_valid, q_pop;
    t_job job, q_job;

    assign o_cfg_ready = 1'b1;

    // register file writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.succ_start   <= CNT_W'(3);
            r_cfg.fail_drop    <= CNT_W'(5);
            r_cfg.gate_radius  <= GATE_W'(800);
            r_cfg.frame_width  <= DIM_W'(1024);
            r_cfg.frame_height <= DIM_W'(1024);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SUCC_START: r_cfg.succ_start   <= i_cfg_data[CNT_W-1:0];
                REG_FAIL_DROP:  r_cfg.fail_drop    <= i_cfg_data[CNT_W-1:0];
                REG_GATE:       r_cfg.gate_radius  <= i_cfg_data[GATE_W-1:0];
                REG_FRAME_W:    r_cfg.frame_width  <= i_cfg_data[DIM_W-1:0];
                REG_FRAME_H:    r_cfg.frame_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    gntt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_in_item),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    gntt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .o_ready (job_ready),
        .i_data  (job),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_job)
    );

    gntt_shape u_shape (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_pop   (q_pop),
        .i_job       (q_job),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_result    (o_out_item)
    );

endmodule
